/* rtl/core/montgomery_mac_inner_product_macros.svh */
// Assertion macros for the Montgomery multiply-accumulate block.
`ifndef MONTGOMERY_MAC_INNER_PRODUCT_MACROS_SVH
`define MONTGOMERY_MAC_INNER_PRODUCT_MACROS_SVH
`ifndef SYNTHESIS
`define MMIP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmip: same-cycle check failed");
`define MMIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmip: next-cycle check failed");
`else
`define MMIP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MMIP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/mmip_pkg.sv */
// Types and constants for the Montgomery multiply-accumulate block.
`default_nettype none
package mmip_pkg;
  localparam int WORD_W     = 16;
  localparam int MOD_W      = 15;
  localparam int TERMS_W    = 3;
  localparam int NUM_TERMS  = 4;
  localparam int NUM_STAGES = 8;
  localparam int MUL_STAGES = 3;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS      = 2'd0,
    CFG_MODULUS_INV  = 2'd1,
    CFG_FINAL_FACTOR = 2'd2,
    CFG_TERMS        = 2'd3
  } cfg_reg_t;

  localparam logic [MOD_W-1:0]   MODULUS_RST      = 15'd7681;
  localparam logic [WORD_W-1:0]  MODULUS_INV_RST  = 16'hE201;
  localparam logic [WORD_W-1:0]  FINAL_FACTOR_RST = 16'd1;
  localparam logic [TERMS_W-1:0] TERMS_RST        = 3'd3;

  typedef logic [MUL_STAGES-1:0] mul_en_t;
endpackage
`default_nettype wire

/* rtl/core/montgomery_mac_inner_product.sv */
// Top level: pipelined Montgomery multiply-accumulate over up to four coefficient pairs.
//
//  channel   dir  width  contents
//  s_axis    in   128    left_0, right_0, left_1, right_1, left_2, right_2, left_3, right_3
//  m_axis    out  16     product_sum
//  cfg       in   2+16   register index, write data
//
// One transaction per cycle is sustained while the output is not stalled.
// Stages: 3 for the pair products and reduction, 1 for the sum, 3 for the
// final-factor multiply, 1 output register. Each stage holds its own valid bit,
// so a stalled output fills the bubbles ahead of it before the input stalls.
// Synchronous reset empties the pipeline and restores the register defaults.
`default_nettype none
`include "montgomery_mac_inner_product_macros.svh"
module montgomery_mac_inner_product (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // left_0, right_0, left_1, right_1, left_2, right_2, left_3, right_3
  input  logic [2*mmip_pkg::NUM_TERMS*mmip_pkg::WORD_W-1:0] s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // product_sum
  output logic [mmip_pkg::WORD_W-1:0]                  m_axis_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [mmip_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [mmip_pkg::WORD_W-1:0]                  cfg_data
);
  import mmip_pkg::*;

  logic [MOD_W-1:0]          modulus;
  logic signed [WORD_W-1:0]  modulus_inverse;
  logic signed [WORD_W-1:0]  final_factor;
  logic [TERMS_W-1:0]        terms_in_use;

  logic [NUM_STAGES-1:0]     valid;
  logic [NUM_STAGES-1:0]     rdy;
  logic [NUM_STAGES-1:0]     vin;
  logic [NUM_STAGES-1:0]     en;

  logic signed [WORD_W-1:0]  term_res [NUM_TERMS];
  logic signed [WORD_W-1:0]  acc;
  logic signed [WORD_W-1:0]  acc_next;
  logic signed [WORD_W-1:0]  final_res;
  logic [WORD_W-1:0]         result;
  logic                      use_2;
  logic                      use_3;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= MODULUS_RST;
      modulus_inverse <= MODULUS_INV_RST;
      final_factor    <= FINAL_FACTOR_RST;
      terms_in_use    <= TERMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MODULUS:      modulus         <= cfg_data[MOD_W-1:0];
        CFG_MODULUS_INV:  modulus_inverse <= cfg_data;
        CFG_FINAL_FACTOR: final_factor    <= cfg_data;
        CFG_TERMS:        terms_in_use    <= cfg_data[TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  // valid/ready chain
  always_comb begin
    rdy[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !valid[i] || rdy[i+1];
    end
    vin[0] = s_axis_tvalid;
    for (int i = 1; i < NUM_STAGES; i++) begin
      vin[i] = valid[i-1];
    end
    en = rdy & vin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          valid[i] <= vin[i];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0] && !rst;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    mmip_mont_mul u_term (
      .clk             (clk),
      .en              (en[MUL_STAGES-1:0]),
      .x               (s_axis_tdata[(2*k)*WORD_W +: WORD_W]),
      .y               (s_axis_tdata[(2*k+1)*WORD_W +: WORD_W]),
      .modulus         (modulus),
      .modulus_inverse (modulus_inverse),
      .res             (term_res[k])
    );
  end

  assign use_2    = terms_in_use > 3'd2;
  assign use_3    = terms_in_use > 3'd3;
  assign acc_next = term_res[0] + term_res[1]
                  + (use_2 ? term_res[2] : '0)
                  + (use_3 ? term_res[3] : '0);

  always_ff @(posedge clk) begin
    if (en[MUL_STAGES]) begin
      acc <= acc_next;
    end
  end

  mmip_mont_mul u_final (
    .clk             (clk),
    .en              (en[2*MUL_STAGES:MUL_STAGES+1]),
    .x               (acc),
    .y               (final_factor),
    .modulus         (modulus),
    .modulus_inverse (modulus_inverse),
    .res             (final_res)
  );

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      result <= final_res;
    end
  end

  assign m_axis_tvalid = valid[NUM_STAGES-1];
  assign m_axis_tdata  = result;

  `MMIP_ASSERT_SAME(a_empty_head_ready, clk, rst, !valid[0], s_axis_tready)
  `MMIP_ASSERT_NEXT(a_accept_fills_head, clk, rst, s_axis_tvalid && s_axis_tready, valid[0])
  `MMIP_ASSERT_NEXT(a_sum_held_on_stall, clk, rst,
                    valid[MUL_STAGES] && !rdy[MUL_STAGES+1],
                    valid[MUL_STAGES] && $stable(acc))
  `MMIP_ASSERT_NEXT(a_out_follows_chain, clk, rst,
                    valid[NUM_STAGES-2] && rdy[NUM_STAGES-1], m_axis_tvalid)
endmodule
`default_nettype wire

/* rtl/core/mmip_mont_mul.sv */
// Three-stage pipelined 16-bit Montgomery multiply (product, low fold, correction).
`default_nettype none
module mmip_mont_mul (
  input  logic                                clk,
  input  mmip_pkg::mul_en_t                   en,
  input  logic signed [mmip_pkg::WORD_W-1:0]  x,
  input  logic signed [mmip_pkg::WORD_W-1:0]  y,
  input  logic        [mmip_pkg::MOD_W-1:0]   modulus,
  input  logic signed [mmip_pkg::WORD_W-1:0]  modulus_inverse,
  output logic signed [mmip_pkg::WORD_W-1:0]  res
);
  import mmip_pkg::*;

  logic signed [2*WORD_W-1:0] prod;
  logic signed [WORD_W-1:0]   fold;
  logic signed [WORD_W-1:0]   fold_next;
  logic signed [WORD_W-1:0]   hi_a;
  logic signed [WORD_W-1:0]   hi_b;
  logic signed [2*WORD_W-1:0] corr;
  logic signed [2*WORD_W-1:0] corr_next;
  logic signed [WORD_W-1:0]   q_s;

  assign fold_next = WORD_W'(prod[WORD_W-1:0] * $unsigned(modulus_inverse));
  assign q_s       = $signed({1'b0, modulus});
  assign corr_next = fold * q_s;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= x * y;
    end
    if (en[1]) begin
      fold <= fold_next;
      hi_a <= prod[2*WORD_W-1:WORD_W];
    end
    if (en[2]) begin
      corr <= corr_next;
      hi_b <= hi_a;
    end
  end

  assign res = hi_b - corr[2*WORD_W-1:WORD_W];
endmodule
`default_nettype wire

/* tb/montgomery_mac_inner_product_test.sv */
// Self-checking testbench for the Montgomery multiply-accumulate inner product block.
module montgomery_mac_inner_product_test;
  import mmip_pkg::*;

  localparam int PIPE_LATENCY    = NUM_STAGES;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_DIRECTED    = 12;
  localparam int NUM_PRESETS     = 8;
  localparam int NUM_COEFFS      = 2 * NUM_TERMS;

  // left_0, right_0, left_1, right_1, ... right_3 from bit 0 up
  typedef logic [NUM_COEFFS*WORD_W-1:0] coeff_set_t;

  typedef struct {
    logic [WORD_W-1:0] vals [NUM_COEFFS];
    bit                typed;
    logic [WORD_W-1:0] sum;
  } directed_row_t;

  typedef struct {
    logic [MOD_W-1:0]   modulus;
    logic [WORD_W-1:0]  modulus_inv;
    logic [WORD_W-1:0]  factor;
    logic [TERMS_W-1:0] terms;
  } mac_settings_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // left_0, right_0, left_1, right_1, left_2, right_2, left_3, right_3
  coeff_set_t         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // product_sum
  logic [WORD_W-1:0]  m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]  cfg_data = '0;

  logic [MOD_W-1:0]   cur_modulus      = MODULUS_RST;
  logic [WORD_W-1:0]  cur_modulus_inv  = MODULUS_INV_RST;
  logic [WORD_W-1:0]  cur_final_factor = FINAL_FACTOR_RST;
  logic [TERMS_W-1:0] cur_terms        = TERMS_RST;

  logic [WORD_W-1:0]  pending_sums [$];
  logic [WORD_W-1:0]  want_sum;
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 idle_mode = 0;
  int                 send_idle_pct [3] = '{19, 83, 0};
  int                 recv_idle_pct [3] = '{83, 19, 0};

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      1'b1, 16'h0000},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
      1'b0, 16'h0000},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
      1'b0, 16'h0000},
    '{'{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000},
      1'b0, 16'h0000},
    // pair 3 is outside the default three terms
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF},
      1'b1, 16'h0000},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF},
      1'b1, 16'h0000},
    '{'{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
      1'b0, 16'h0000},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      1'b0, 16'h0000},
    // low product half is zero
    '{'{16'h8000, 16'h0002, 16'h8000, 16'h0002, 16'h8000, 16'h0002, 16'h8000, 16'h0002},
      1'b0, 16'h0000},
    '{'{16'h1234, 16'h0000, 16'hFEDC, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000},
      1'b1, 16'h0000},
    '{'{16'h0001, 16'h1E01, 16'hFFFF, 16'h1E01, 16'h1E01, 16'h1E01, 16'h0002, 16'h0003},
      1'b0, 16'h0000},
    '{'{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA},
      1'b0, 16'h0000}
  };

  // terms 0/1 act as 2, terms 5..7 act as 4; even and mismatched moduli used as given
  mac_settings_t presets [NUM_PRESETS] = '{
    '{15'd7681,  16'hE201, 16'h0001, 3'd3},
    '{15'd3329,  16'hF301, 16'd1353, 3'd2},
    '{15'd3,     16'h8000, 16'h8000, 3'd0},
    '{15'd32767, 16'h7FFF, 16'h7FFF, 3'd7},
    '{15'd3329,  16'hF301, 16'hFFFF, 3'd1},
    '{15'd7681,  16'hE201, 16'h0000, 3'd4},
    '{15'd12289, 16'h2FFF, 16'h0800, 3'd5},
    '{15'd4096,  16'h1234, 16'h0001, 3'd6}
  };

  montgomery_mac_inner_product uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [WORD_W-1:0] mont_mul16(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] y);
    int                prod;
    int                corr;
    logic [31:0]       low_prod;
    logic [WORD_W-1:0] m;
    prod = int'($signed(x)) * int'($signed(y));
    low_prod = prod[15:0] * cur_modulus_inv;
    m = low_prod[15:0];
    corr = int'($signed(m)) * int'(cur_modulus);
    return prod[31:16] - corr[31:16];
  endfunction

  function automatic logic [WORD_W-1:0] expected_product_sum(input coeff_set_t c);
    logic [WORD_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (k < 2 || k < cur_terms) begin
        acc += mont_mul16(c[2*k*WORD_W +: WORD_W], c[(2*k+1)*WORD_W +: WORD_W]);
      end
    end
    return mont_mul16(acc, cur_final_factor);
  endfunction

  task automatic send_item(input coeff_set_t c, input logic [WORD_W-1:0] sum);
    while ($urandom_range(99) < send_idle_pct[idle_mode]) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_sums.push_back(sum);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODULUS:      cur_modulus = data[MOD_W-1:0];
      CFG_MODULUS_INV:  cur_modulus_inv = data;
      CFG_FINAL_FACTOR: cur_final_factor = data;
      CFG_TERMS:        cur_terms = data[TERMS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct[idle_mode]);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        $error("product_sum: unexpected transaction, got %0d", $signed(m_axis_tdata));
        errors++;
      end else begin
        want_sum = pending_sums.pop_front();
        if (m_axis_tdata !== want_sum) begin
          $error("product_sum: expected %0d, got %0d", $signed(want_sum),
                 $signed(m_axis_tdata));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("montgomery_mac_inner_product_test: FAIL");
      $finish;
    end
  end

  initial begin
    coeff_set_t    item;
    mac_settings_t s;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      for (int i = 0; i < NUM_COEFFS; i++) item[i*WORD_W +: WORD_W] = directed_rows[r].vals[i];
      send_item(item, directed_rows[r].typed ? directed_rows[r].sum
                                             : expected_product_sum(item));
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      idle_mode = p * 3 / PHASES;
      if (p < NUM_PRESETS) begin
        s = presets[p];
      end else begin
        s.modulus = MOD_W'($urandom_range(3, 2**MOD_W - 1));
        s.modulus_inv = WORD_W'($urandom);
        s.factor = WORD_W'($urandom);
        s.terms = TERMS_W'($urandom_range(0, 7));
      end
      cfg_write(CFG_MODULUS, {1'b0, s.modulus});
      cfg_write(CFG_MODULUS_INV, s.modulus_inv);
      cfg_write(CFG_FINAL_FACTOR, s.factor);
      cfg_write(CFG_TERMS, {13'd0, s.terms});
      cfg_valid <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        for (int i = 0; i < NUM_COEFFS; i++) begin
          case ($urandom_range(9))
            0:       item[i*WORD_W +: WORD_W] = 16'h8000;
            1:       item[i*WORD_W +: WORD_W] = 16'h7FFF;
            2:       item[i*WORD_W +: WORD_W] = 16'h0000;
            3:       item[i*WORD_W +: WORD_W] = 16'hFFFF;
            default: item[i*WORD_W +: WORD_W] = 16'($urandom);
          endcase
        end
        send_item(item, expected_product_sum(item));
      end
    end

    wait_drained();
    repeat (PIPE_LATENCY) @(negedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("montgomery_mac_inner_product_test: PASS");
    end else begin
      $display("montgomery_mac_inner_product_test: FAIL");
    end
    $finish;
  end
endmodule
